// File: rtl/segred_pkg.sv
// ----------------------------------------------------------------------------
// segred_pkg
// Operation codes for the segmented reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package segred_pkg;

	localparam int unsigned OP_WIDTH = 3;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_SUM  = 3'd0,
		OP_PROD = 3'd1,
		OP_MIN  = 3'd2,
		OP_MAX  = 3'd3,
		OP_LAND = 3'd4,
		OP_LOR  = 3'd5,
		OP_BAND = 3'd6,
		OP_BOR  = 3'd7
	} reduce_op_t;

endpackage

`default_nettype wire

// File: rtl/segmented_reduction_unit.sv
// ----------------------------------------------------------------------------
// segmented_reduction_unit
// Reduces a stream of signed values into one result per closed segment, using
// the operation held in the reduce_op register.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  item      item_valid / item_stall       value, value_present, segment_end
//  result    result_valid / result_stall   reduced
//  config    reduce_op_valid / _ready      reduce_op
//
//  One item per cycle through an input register and the accumulator stage
//  when not stalled. A product element stalls while the split multiplier's
//  partial products are registered before the accumulator is updated.
//  Reset sets the operation to sum and the running total to zero.
//  A stalled result holds a segment-closing item in the input register and
//  stalls the input; items that close nothing still update the total.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_reduction_unit #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic signed [63:0]                   value,
	input  wire logic                                 value_present,
	input  wire logic                                 segment_end,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [63:0]                        reduced,
	input  wire logic                                 reduce_op_valid,
	output logic                                      reduce_op_ready,
	input  wire logic [segred_pkg::OP_WIDTH-1:0]      reduce_op
);

	localparam int unsigned W    = VALUE_WIDTH;
	localparam int unsigned HALF = (W + 1) / 2;
	localparam int unsigned HI   = W - HALF;

	function automatic logic [W-1:0] identity_of(input segred_pkg::reduce_op_t op);
		logic [W-1:0] id;
		begin
			id = '0;
			unique case (op)
				segred_pkg::OP_PROD, segred_pkg::OP_LAND: id = W'(1);
				segred_pkg::OP_MIN: id = {1'b0, {(W-1){1'b1}}};
				segred_pkg::OP_MAX: id = {1'b1, {(W-1){1'b0}}};
				segred_pkg::OP_BAND: id = '1;
				default: id = '0;
			endcase
			return id;
		end
	endfunction

	segred_pkg::reduce_op_t op_q;
	logic [W-1:0]           acc_q;

	logic                   valid_s1;
	logic [W-1:0]           value_s1;
	logic                   has_s1;
	logic                   end_s1;

	logic [2*HALF-1:0]      pp_ll_q;
	logic [HI-1:0]          pp_x_q;
	logic                   prod_phase_q;

	logic                   result_valid_q;
	logic [W-1:0]           reduced_q;

	logic                   need_pp;
	logic                   out_blocked;
	logic                   advance;
	logic                   accept;
	logic [HALF-1:0]        a_lo;
	logic [HALF-1:0]        b_lo;
	logic [HI-1:0]          a_hi;
	logic [HI-1:0]          b_hi;
	logic [2*HALF-1:0]      ll_d;
	logic [HI-1:0]          x_d;
	logic [W-1:0]           prod_d;
	logic [W-1:0]           comb_d;
	logic [W-1:0]           total_d;

	assign need_pp     = valid_s1 && has_s1 && (op_q == segred_pkg::OP_PROD) && !prod_phase_q;
	assign out_blocked = end_s1 && result_valid_q && result_stall;
	assign advance     = valid_s1 && !need_pp && !out_blocked;
	assign item_stall  = valid_s1 && !advance;
	assign accept      = item_valid && !item_stall;

	assign reduce_op_ready = !valid_s1 && !item_valid;
	assign result_valid    = result_valid_q;
	assign reduced         = 64'(signed'(reduced_q));

	assign a_lo = acc_q[HALF-1:0];
	assign a_hi = acc_q[W-1:HALF];
	assign b_lo = value_s1[HALF-1:0];
	assign b_hi = value_s1[W-1:HALF];
	assign ll_d = {{HALF{1'b0}}, a_lo} * {{HALF{1'b0}}, b_lo};
	assign x_d  = a_lo[HI-1:0] * b_hi + a_hi * b_lo[HI-1:0];
	assign prod_d = pp_ll_q[W-1:0] + {pp_x_q, {HALF{1'b0}}};

	always_comb begin
		comb_d = acc_q;
		case (op_q)
			segred_pkg::OP_SUM:  comb_d = acc_q + value_s1;
			segred_pkg::OP_PROD: comb_d = prod_d;
			segred_pkg::OP_MIN:  comb_d = ($signed(value_s1) < $signed(acc_q)) ? value_s1 : acc_q;
			segred_pkg::OP_MAX:  comb_d = ($signed(acc_q) < $signed(value_s1)) ? value_s1 : acc_q;
			segred_pkg::OP_LAND: comb_d = W'((acc_q != '0) && (value_s1 != '0));
			segred_pkg::OP_LOR:  comb_d = W'((acc_q != '0) || (value_s1 != '0));
			segred_pkg::OP_BAND: comb_d = acc_q & value_s1;
			default:             comb_d = acc_q | value_s1;
		endcase
		total_d = has_s1 ? comb_d : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= value[W-1:0];
			has_s1   <= value_present;
			end_s1   <= segment_end;
		end
	end

	always_ff @(posedge clk) begin
		if (need_pp) begin
			pp_ll_q <= ll_d;
			pp_x_q  <= x_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_phase_q <= 1'b0;
		end else if (advance) begin
			prod_phase_q <= 1'b0;
		end else if (need_pp) begin
			prod_phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= segred_pkg::OP_SUM;
			acc_q <= '0;
		end else if (reduce_op_valid && reduce_op_ready) begin
			op_q  <= segred_pkg::reduce_op_t'(reduce_op);
			acc_q <= identity_of(segred_pkg::reduce_op_t'(reduce_op));
		end else if (advance) begin
			acc_q <= end_s1 ? identity_of(op_q) : total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			reduced_q <= total_d;
		end
	end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segmented_reduction_unit. A directed opening
// exercises every reduction operation at its extremes, empty segments, idle
// items and an operation change over an open segment. Random segments under
// changing operations follow, with bursty idling on the item and result channels. An
// in-bench accumulator predicts each segment total, and every result is
// checked in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned LONG_HOLD = 160;
	localparam int unsigned PHASE_ITEMS = 112;
	localparam logic signed [63:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		logic signed [63:0] value;
		logic value_present;
		logic segment_end;
	} seg_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [63:0] value = '0;
	logic value_present = 1'b0;
	logic segment_end = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [63:0] reduced;
	logic reduce_op_valid = 1'b0;
	logic reduce_op_ready;
	logic [segred_pkg::OP_WIDTH-1:0] reduce_op = segred_pkg::OP_SUM;

	seg_item_t pending_items[$];
	logic signed [63:0] totals_due[$];
	segred_pkg::reduce_op_t op_model = segred_pkg::OP_SUM;
	logic signed [63:0] acc_model = '0;
	logic item_fire_q = 1'b0;
	int unsigned idle_pct = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned fail_count = 0;
	int unsigned totals_checked = 0;
	int unsigned items_taken = 0;
	int unsigned op_writes = 0;
	int unsigned cycle_count = 0;

	segmented_reduction_unit #(
		.VALUE_WIDTH(64)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.value(value),
		.value_present(value_present),
		.segment_end(segment_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.reduced(reduced),
		.reduce_op_valid(reduce_op_valid),
		.reduce_op_ready(reduce_op_ready),
		.reduce_op(reduce_op)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [63:0] op_identity(segred_pkg::reduce_op_t op);
		case (op)
			segred_pkg::OP_PROD, segred_pkg::OP_LAND: return 64'sd1;
			segred_pkg::OP_MIN: return VAL_MAX;
			segred_pkg::OP_MAX: return VAL_MIN;
			segred_pkg::OP_BAND: return -64'sd1;
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [63:0] op_fold(segred_pkg::reduce_op_t op,
			logic signed [63:0] acc, logic signed [63:0] x);
		case (op)
			segred_pkg::OP_SUM: return acc + x;
			segred_pkg::OP_PROD: return acc * x;
			segred_pkg::OP_MIN: return (x < acc) ? x : acc;
			segred_pkg::OP_MAX: return (acc < x) ? x : acc;
			segred_pkg::OP_LAND: return (acc != 0 && x != 0) ? 64'sd1 : 64'sd0;
			segred_pkg::OP_LOR: return (acc != 0 || x != 0) ? 64'sd1 : 64'sd0;
			segred_pkg::OP_BAND: return acc & x;
			default: return acc | x;
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		logic signed [63:0] want;
		if (!arst_n) begin
			op_model = segred_pkg::OP_SUM;
			acc_model = '0;
			item_fire_q <= 1'b0;
		end else begin
			item_fire_q <= item_valid && !item_stall;
			if (reduce_op_valid && reduce_op_ready) begin
				op_model = segred_pkg::reduce_op_t'(reduce_op);
				acc_model = op_identity(op_model);
				op_writes++;
			end
			if (item_valid && !item_stall) begin
				items_taken++;
				if (value_present)
					acc_model = op_fold(op_model, acc_model, value);
				if (segment_end) begin
					totals_due.push_back(acc_model);
					acc_model = op_identity(op_model);
				end
			end
			if (result_valid && !result_stall) begin
				if (totals_due.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, reduced);
					fail_count++;
				end else begin
					want = totals_due.pop_front();
					totals_checked++;
					if (reduced !== want) begin
						$display("%0t reduced mismatch: expected %h, actual %h",
							$time, want, reduced);
						fail_count++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		seg_item_t nxt;
		if (arst_n && !(item_valid && !item_fire_q)) begin
			if (send_gap != 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				item_valid <= 1'b1;
				value <= nxt.value;
				value_present <= nxt.value_present;
				segment_end <= nxt.segment_end;
				if ($urandom_range(0, 99) < idle_pct)
					send_gap = $urandom_range(1, 6);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(logic signed [63:0] v, logic vp, logic se);
		seg_item_t it;
		it.value = v;
		it.value_present = vp;
		it.segment_end = se;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [63:0] pick_value();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 64'sd1;
			2: return -64'sd1;
			3: return VAL_MAX;
			4: return VAL_MIN;
			5: return $signed(64'($urandom_range(0, 16))) - 64'sd8;
			6: return 64'sd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_segment(output int unsigned counted);
		int unsigned n;
		logic close_on_last;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
		close_on_last = (n != 0) && ($urandom_range(0, 1) == 1);
		counted = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(pick_value(), 1'b0, 1'b0);
				counted++;
			end
			push_item(pick_value(), 1'b1, close_on_last && i == n - 1);
			counted++;
		end
		if (!close_on_last) begin
			push_item(pick_value(), 1'b0, 1'b1);
			counted++;
		end
	endtask

	task automatic random_segments(int unsigned quota);
		int unsigned got;
		int unsigned c;
		got = 0;
		while (got < quota) begin
			push_segment(c);
			got += c;
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || totals_due.size() != 0)
			@(posedge clk);
	endtask

	// drain, then let items that close nothing clear the pipeline
	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_op(segred_pkg::reduce_op_t op);
		settle();
		@(negedge clk);
		reduce_op_valid <= 1'b1;
		reduce_op <= op;
		@(posedge clk);
		while (!reduce_op_ready)
			@(posedge clk);
		@(negedge clk);
		reduce_op_valid <= 1'b0;
	endtask

	task automatic directed_op(segred_pkg::reduce_op_t op, logic signed [63:0] a,
			logic signed [63:0] b);
		write_op(op);
		push_item(a, 1'b1, 1'b0);
		push_item(b, 1'b1, 1'b1);
		push_item(pick_value(), 1'b0, 1'b1);
	endtask

	initial begin : stimulus
		int unsigned open_len;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sum from reset: wrap past the top, empty segment, idle item, open tail
		push_item(VAL_MAX, 1'b1, 1'b0);
		push_item(64'sd1, 1'b1, 1'b1);
		push_item(pick_value(), 1'b0, 1'b0);
		push_item(pick_value(), 1'b0, 1'b1);
		push_item(-64'sd1, 1'b1, 1'b0);
		directed_op(segred_pkg::OP_PROD, VAL_MIN, -64'sd1);
		directed_op(segred_pkg::OP_MIN, VAL_MAX, VAL_MIN);
		directed_op(segred_pkg::OP_MAX, VAL_MIN, VAL_MAX);
		directed_op(segred_pkg::OP_LAND, -64'sd1, '0);
		directed_op(segred_pkg::OP_LOR, '0, VAL_MIN);
		directed_op(segred_pkg::OP_BAND, VAL_MAX, -64'sd1);
		directed_op(segred_pkg::OP_BOR, VAL_MIN, 64'sd1);

		for (int unsigned k = 0; k < 10; k++) begin
			write_op((k < 8) ? segred_pkg::reduce_op_t'(k)
				: segred_pkg::reduce_op_t'($urandom_range(0, 7)));
			case (k % 4)
				0: idle_pct = 25;
				1: idle_pct = 10;
				2: idle_pct = 0;
				default: idle_pct = 40;
			endcase
			if (k == 9)
				idle_pct = 0;
			if (k == 5) begin
				random_segments(PHASE_ITEMS / 2);
				wait_drained();
				random_segments(PHASE_ITEMS / 2);
			end else begin
				random_segments(PHASE_ITEMS);
			end
			if (k == 3)
				hold_req++;
			// leave a partial segment for the next operation change to drop
			if (k != 9 && $urandom_range(0, 1) == 1) begin
				open_len = $urandom_range(1, 3);
				repeat (open_len) push_item(pick_value(), 1'b1, 1'b0);
			end
		end

		settle();
		$display("covered %0d items and %0d segment totals over %0d operation changes",
			items_taken, totals_checked, op_writes);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
